// ===== rtl/core/rwa_pkg.sv =====
// ----------------------------------------------------------------------------
// Running window average package
// Shared sizes, request codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rwa_pkg;

   localparam int MAX_WINDOW    = 256;
   localparam int SAMPLE_BITS   = 16;
   localparam int CFG_BITS      = 9;
   localparam int WINDOW_RESET  = 16;
   localparam int PTR_BITS      = $clog2(MAX_WINDOW);
   localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS;
   localparam int REM_BITS      = CNT_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

   localparam logic REQ_SAMPLE  = 1'b0;
   localparam logic REQ_CLEAR   = 1'b1;

   typedef struct packed {
      logic clear;
      logic accept;
      logic update;
      logic div_step;
      logic load_out;
   } rwa_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } rwa_status_type;

endpackage

// ===== rtl/core/rwa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rwa_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 256
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Running window average controller
// Sequences one sample through store update, serial division and output.
// ----------------------------------------------------------------------------
module rwa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   output logic                   req_stall,
   input  rwa_pkg::rwa_status_type status,
   output rwa_pkg::rwa_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.clear    = accept && (req_type == rwa_pkg::REQ_CLEAR);
      cmd.accept   = accept && (req_type == rwa_pkg::REQ_SAMPLE);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rwa_datapath.sv =====
// ----------------------------------------------------------------------------
// Running window average datapath
// Sample ring, running sum, fill count, serial divider and output register.
// ----------------------------------------------------------------------------
module rwa_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rwa_pkg::rwa_cmd_type                   cmd,
   output rwa_pkg::rwa_status_type                status,
   input  logic signed [rwa_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   csr_write_enable,
   input  logic [rwa_pkg::CFG_BITS-1:0]           csr_write_data,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [rwa_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic                                   rsp_window_full
);

   localparam int SB  = rwa_pkg::SAMPLE_BITS;
   localparam int PB  = rwa_pkg::PTR_BITS;
   localparam int CB  = rwa_pkg::CNT_BITS;
   localparam int UB  = rwa_pkg::SUM_BITS;
   localparam int RB  = rwa_pkg::REM_BITS;
   localparam int DB  = rwa_pkg::DIV_CNT_BITS;
   localparam int FB  = rwa_pkg::CFG_BITS;

   logic [FB-1:0]        window_size_ff, window_size_in;
   logic [PB-1:0]        wpos_ff, wpos_in;
   logic [CB-1:0]        fill_ff, fill_in;
   logic signed [UB-1:0] sum_ff, sum_in;
   logic signed [SB-1:0] sample_ff;
   logic [PB-1:0]        pos_ff;

   logic [UB-1:0]        quo_ff, quo_in;
   logic [RB-1:0]        rem_ff, rem_in;
   logic [CB-1:0]        den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DB-1:0]        cnt_ff, cnt_in;

   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_average_ff;
   logic                 rsp_window_full_ff;

   logic [CB-1:0]        cap;
   logic [PB-1:0]        pos_cur;
   logic [CB-1:0]        pos_inc;
   logic                 full;
   logic [SB-1:0]        ram_rd_data;
   logic signed [UB-1:0] old_ext;
   logic signed [UB-1:0] sum_upd;
   logic [CB-1:0]        fill_upd;
   logic [RB-1:0]        rem_sh;
   logic [UB-1:0]        quo_signed;

   always_comb begin
      if (window_size_ff == '0) begin
         cap = CB'(1);
      end else if (32'(window_size_ff) > 32'(rwa_pkg::MAX_WINDOW)) begin
         cap = CB'(rwa_pkg::MAX_WINDOW);
      end else begin
         cap = CB'(window_size_ff);
      end
   end

   assign pos_cur = (CB'(wpos_ff) >= cap) ? '0 : wpos_ff;
   assign pos_inc = CB'(pos_ff) + CB'(1);
   assign full    = (fill_ff == cap);

   rwa_ram #(
      .DATA_WIDTH (SB),
      .DEPTH      (rwa_pkg::MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (pos_cur),
      .rd_data (ram_rd_data)
   );

   assign old_ext  = full ? UB'($signed(ram_rd_data)) : '0;
   assign sum_upd  = sum_ff + UB'(sample_ff) - old_ext;
   assign fill_upd = full ? fill_ff : fill_ff + CB'(1);
   assign rem_sh   = {rem_ff[RB-2:0], quo_ff[UB-1]};

   always_comb begin
      window_size_in = window_size_ff;
      wpos_in        = wpos_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      if (csr_write_enable) begin
         window_size_in = csr_write_data;
      end
      if (csr_write_enable || cmd.clear) begin
         wpos_in = '0;
         fill_in = '0;
         sum_in  = '0;
      end
      if (cmd.update) begin
         sum_in  = sum_upd;
         fill_in = fill_upd;
         wpos_in = (pos_inc >= cap) ? '0 : PB'(pos_inc);
         quo_in  = sum_upd[UB-1] ? UB'(-sum_upd) : UB'(sum_upd);
         rem_in  = '0;
         den_in  = fill_upd;
         neg_in  = sum_upd[UB-1];
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         cnt_in = cnt_ff + DB'(1);
         if (rem_sh >= RB'(den_ff)) begin
            rem_in = rem_sh - RB'(den_ff);
            quo_in = {quo_ff[UB-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[UB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= FB'(rwa_pkg::WINDOW_RESET);
         wpos_ff        <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
      end else begin
         window_size_ff <= window_size_in;
         wpos_ff        <= wpos_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (cmd.accept) begin
         sample_ff <= req_sample;
         pos_ff    <= pos_cur;
      end
   end

   assign quo_signed = neg_ff ? -quo_ff : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_average_ff     <= SB'(quo_signed);
         rsp_window_full_ff <= full;
      end
   end

   assign status.div_last = (cnt_ff == DB'(UB - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_window_full = rsp_window_full_ff;

endmodule

// ===== rtl/core/running_window_average_unit.sv =====
// ----------------------------------------------------------------------------
// Running window average unit
// Moving average over the most recent samples, kept as a running sum.
// ----------------------------------------------------------------------------
// A sample request occupies the unit until its result is loaded, so the next
// sample is accepted only after that. The cycle in which it is accepted reads
// the oldest sample from the ring memory. The update state then updates the
// sum and the ring. The one-bit-per-cycle divider then divides the 24-bit sum
// by the fill count, and the finish state loads the result into the output
// register. A clear request is accepted while the unit is idle without
// occupying it and returns nothing. The result register holds one finished
// average while the next request is already being worked on. A request that
// finishes while that average is still stalled waits in its finish state until
// the register is free.
module running_window_average_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic signed [rwa_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rwa_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic                                   rsp_window_full,
   input  logic                                   csr_write_enable,
   input  logic [rwa_pkg::CFG_BITS-1:0]           csr_write_data
);

   rwa_pkg::rwa_cmd_type    cmd;
   rwa_pkg::rwa_status_type status;

   rwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rwa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_average      (rsp_average),
      .rsp_window_full  (rsp_window_full)
   );

endmodule

// ===== rtl/core/running_window_average_unit_chk.sv =====
// ----------------------------------------------------------------------------
// Running window average port checker
// Checks request and response behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module running_window_average_unit_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_type,
   input logic signed [rwa_pkg::SAMPLE_BITS-1:0] req_sample,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [rwa_pkg::SAMPLE_BITS-1:0] rsp_average,
   input logic                                   rsp_window_full,
   input logic                                   csr_write_enable,
   input logic [rwa_pkg::CFG_BITS-1:0]           csr_write_data
);

   logic take_sample;
   logic take_clear;

   assign take_sample = req_valid && !req_stall && (req_type == rwa_pkg::REQ_SAMPLE);
   assign take_clear  = req_valid && !req_stall && (req_type == rwa_pkg::REQ_CLEAR);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average)
                                 && $stable(rsp_window_full))
      else $error("Stalled response changed or was dropped.");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> req_stall)
      else $error("Request port ready right after a sample request.");

   a_clear_single_cycle: assert property (@(posedge clock) disable iff (reset)
      take_clear |=> !req_stall)
      else $error("Clear request did not complete in one cycle.");

   a_clear_no_response: assert property (@(posedge clock) disable iff (reset)
      take_clear && !rsp_valid |=> !rsp_valid)
      else $error("Clear request produced a response.");

   a_no_early_response: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> ##1 !$rose(rsp_valid))
      else $error("Response appeared before the division could finish.");

endmodule

bind running_window_average_unit running_window_average_unit_chk u_chk (.*);
